>>> rtl/rpn_pkg.sv
// Shared types and constants of the RPN stack calculator.
package rpn_pkg;

  localparam int STACK_DEPTH = 4;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int Q_W = 32;
  localparam int FRAC_W = 16;
  localparam int DEPTH_OUT_W = 3;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REQ_NUM     = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_SUB     = 3'd2,
    REQ_MUL     = 3'd3,
    REQ_DIV     = 3'd4,
    REQ_PEEK    = 3'd5,
    REQ_EOL     = 3'd6,
    REQ_INVALID = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_OVERFLOW  = 4'd1,
    ST_UNDERFLOW = 4'd2,
    ST_DIVZERO   = 4'd3,
    ST_EMPTY     = 4'd4,
    ST_INVALID   = 4'd5,
    ST_SKIPPED   = 4'd6,
    ST_CLEARED   = 4'd7,
    ST_KEPT      = 4'd8,
    ST_SAT       = 4'd9
  } status_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic signed [Q_W-1:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]             status;
    logic signed [Q_W-1:0]  result_value;
    logic [DEPTH_OUT_W-1:0] depth_out;
  } out_word_t;

  typedef struct packed {
    logic           eol;
    logic           push;
    logic           arith;
    logic           peek;
    alu_op_t        alu;
    logic [Q_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] dividend;
    logic [Q_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic           sat;
    logic [Q_W-1:0] value;
  } div_res_t;

endpackage

>>> rtl/rpn_front.sv
// Front end: accepts input words and decodes them into commands for the queue.
module rpn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rpn_pkg::in_word_t in_data,
  output logic              push,
  output rpn_pkg::cmd_t     push_data,
  input  logic              q_full
);
  import rpn_pkg::*;

  logic valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic load;

  always_comb begin
    cmd_nxt = '0;
    cmd_nxt.value = in_data.operand_value;
    case (in_data.req_type)
      REQ_NUM: begin
        cmd_nxt.push = 1'b1;
      end
      REQ_ADD: begin
        cmd_nxt.arith = 1'b1;
        cmd_nxt.alu = ALU_ADD;
      end
      REQ_SUB: begin
        cmd_nxt.arith = 1'b1;
        cmd_nxt.alu = ALU_SUB;
      end
      REQ_MUL: begin
        cmd_nxt.arith = 1'b1;
        cmd_nxt.alu = ALU_MUL;
      end
      REQ_DIV: begin
        cmd_nxt.arith = 1'b1;
        cmd_nxt.alu = ALU_DIV;
      end
      REQ_PEEK: begin
        cmd_nxt.peek = 1'b1;
      end
      REQ_EOL: begin
        cmd_nxt.eol = 1'b1;
      end
      default: begin
        cmd_nxt.alu = ALU_ADD;
      end
    endcase
  end

  assign push      = valid_r && !q_full;
  assign in_stall  = valid_r && q_full;
  assign load      = in_valid && !in_stall;
  assign push_data = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

>>> rtl/rpn_queue.sv
// Short command queue between the front end and the execution unit.
module rpn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpn_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output rpn_pkg::cmd_t pop_data,
  output logic          empty
);
  import rpn_pkg::*;

  localparam int QD   = 2;
  localparam int Q_AW = $clog2(QD);
  localparam int Q_CW = $clog2(QD + 1);

  cmd_t            entry_r [QD];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == Q_CW'(QD));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(QD - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(QD - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/rpn_div.sv
// Radix-4 restoring divider for Q16.16 quotients with saturation.
module rpn_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::div_req_t req,
  output rpn_pkg::div_res_t res
);
  import rpn_pkg::*;

  localparam int DIV_QW    = Q_W + FRAC_W;
  localparam int DIV_RAD   = 2;
  localparam int DIV_STEPS = DIV_QW / DIV_RAD;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [Q_W-1:0]    rem_r;
  logic [DIV_QW-1:0] quo_r;
  logic [Q_W-1:0]    dsr_r;
  logic              neg_r;

  logic [Q_W-1:0]    abs_l;
  logic [Q_W-1:0]    abs_r;
  logic [Q_W:0]      rem_t;
  logic [Q_W:0]      rem_sh;
  logic [DIV_QW-1:0] quo_t;
  logic              over_pos;
  logic              over_neg;

  assign abs_l = req.dividend[Q_W-1] ? (Q_W'(0) - req.dividend) : req.dividend;
  assign abs_r = req.divisor[Q_W-1] ? (Q_W'(0) - req.divisor) : req.divisor;

  always_comb begin
    rem_t  = {1'b0, rem_r};
    quo_t  = quo_r;
    rem_sh = '0;
    for (int k = 0; k < DIV_RAD; k++) begin
      rem_sh = {rem_t[Q_W-1:0], quo_t[DIV_QW-1]};
      quo_t  = {quo_t[DIV_QW-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_t    = rem_sh - {1'b0, dsr_r};
        quo_t[0] = 1'b1;
      end else begin
        rem_t = rem_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= {abs_l, FRAC_W'(0)};
      dsr_r <= abs_r;
      neg_r <= req.dividend[Q_W-1] ^ req.divisor[Q_W-1];
    end else if (busy_r) begin
      rem_r <= rem_t[Q_W-1:0];
      quo_r <= quo_t;
    end
  end

  assign over_pos = |quo_r[DIV_QW-1:Q_W-1];
  assign over_neg = (|quo_r[DIV_QW-1:Q_W]) || (quo_r[Q_W-1] && (|quo_r[Q_W-2:0]));

  always_comb begin
    res.done = done_r;
    if (neg_r) begin
      res.sat   = over_neg;
      res.value = over_neg ? Q_MIN : (Q_W'(0) - quo_r[Q_W-1:0]);
    end else begin
      res.sat   = over_pos;
      res.value = over_pos ? Q_MAX : quo_r[Q_W-1:0];
    end
  end

endmodule

>>> rtl/rpn_exec.sv
// Execution unit: value stack, line flags, arithmetic sequencing and result register.
module rpn_exec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rpn_pkg::cmd_t      q_data,
  output logic               q_pop,
  output rpn_pkg::div_req_t  div_req,
  input  rpn_pkg::div_res_t  div_res,
  output logic               out_valid,
  input  logic               out_stall,
  output rpn_pkg::out_word_t out_data
);
  import rpn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [Q_W-1:0] stk_mem [STACK_DEPTH];

  cmd_t              cmd_r;
  logic [CNT_W-1:0]  depth_r;
  logic              skip_r;
  logic              err_r;
  logic [Q_W-1:0]    top_r;
  logic [Q_W-1:0]    sub_r;
  logic signed [2*Q_W-1:0] prod_r;

  logic [Q_W-1:0]    res_r;
  logic [Q_W-1:0]    res_nxt;
  status_t           stat_r;
  status_t           stat_nxt;
  logic [CNT_W-1:0]  pdep_r;
  logic [CNT_W-1:0]  pdep_nxt;
  logic              perr_r;
  logic              perr_nxt;
  logic              pskip_r;
  logic              pskip_nxt;
  logic              wen_r;
  logic              wen_nxt;
  logic [ADDR_W-1:0] widx_r;
  logic [ADDR_W-1:0] widx_nxt;

  logic              out_valid_r;
  out_word_t         out_data_r;

  logic              out_free;
  logic              fin;
  logic              div_start;
  logic [CNT_W-1:0]  dm1;
  logic [CNT_W-1:0]  dm2;
  logic [Q_W:0]      sum_w;
  logic [Q_W:0]      diff_w;
  logic              sum_sat;
  logic              diff_sat;
  logic [Q_W-1:0]    sum_val;
  logic [Q_W-1:0]    diff_val;
  logic signed [2*Q_W-1:0] mul_adj;
  logic [Q_W+FRAC_W-1:0]   mul_q;
  logic              mul_fit;
  logic [Q_W-1:0]    mul_val;

  assign out_free = !out_valid_r || !out_stall;
  assign dm1      = depth_r - CNT_W'(1);
  assign dm2      = depth_r - CNT_W'(2);

  assign sum_w    = {sub_r[Q_W-1], sub_r} + {top_r[Q_W-1], top_r};
  assign diff_w   = {sub_r[Q_W-1], sub_r} - {top_r[Q_W-1], top_r};
  assign sum_sat  = sum_w[Q_W] ^ sum_w[Q_W-1];
  assign diff_sat = diff_w[Q_W] ^ diff_w[Q_W-1];
  assign sum_val  = sum_sat ? (sum_w[Q_W] ? Q_MIN : Q_MAX) : sum_w[Q_W-1:0];
  assign diff_val = diff_sat ? (diff_w[Q_W] ? Q_MIN : Q_MAX) : diff_w[Q_W-1:0];

  assign mul_adj = prod_r + (prod_r[2*Q_W-1] ? (2*Q_W)'((1 << FRAC_W) - 1) : (2*Q_W)'(0));
  assign mul_q   = mul_adj[2*Q_W-1:FRAC_W];
  assign mul_fit = (&mul_q[Q_W+FRAC_W-1:Q_W-1]) || !(|mul_q[Q_W+FRAC_W-1:Q_W-1]);
  assign mul_val = mul_fit ? mul_q[Q_W-1:0] : (mul_q[Q_W+FRAC_W-1] ? Q_MIN : Q_MAX);

  assign div_req.start    = div_start;
  assign div_req.dividend = sub_r;
  assign div_req.divisor  = top_r;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    pdep_nxt  = pdep_r;
    perr_nxt  = perr_r;
    pskip_nxt = pskip_r;
    wen_nxt   = wen_r;
    widx_nxt  = widx_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    fin       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        stat_nxt  = ST_OK;
        pdep_nxt  = depth_r;
        perr_nxt  = err_r;
        pskip_nxt = skip_r;
        wen_nxt   = 1'b0;
        widx_nxt  = depth_r[ADDR_W-1:0];
        state_nxt = S_FIN;
        if (cmd_r.eol) begin
          if (err_r) begin
            stat_nxt = ST_KEPT;
          end else begin
            stat_nxt = ST_CLEARED;
            pdep_nxt = '0;
          end
          perr_nxt  = 1'b0;
          pskip_nxt = 1'b0;
        end else if (skip_r) begin
          stat_nxt = ST_SKIPPED;
        end else if (cmd_r.push) begin
          if (depth_r == CNT_W'(STACK_DEPTH)) begin
            stat_nxt  = ST_OVERFLOW;
            pdep_nxt  = '0;
            perr_nxt  = 1'b1;
            pskip_nxt = 1'b1;
          end else begin
            wen_nxt  = 1'b1;
            res_nxt  = cmd_r.value;
            pdep_nxt = depth_r + CNT_W'(1);
          end
        end else if (cmd_r.arith) begin
          if (depth_r < CNT_W'(2)) begin
            stat_nxt = ST_UNDERFLOW;
            perr_nxt = 1'b1;
          end else if ((cmd_r.alu == ALU_DIV) && (top_r == '0)) begin
            stat_nxt = ST_DIVZERO;
            res_nxt  = sub_r;
            pdep_nxt = dm1;
          end else begin
            pdep_nxt = dm1;
            wen_nxt  = 1'b1;
            widx_nxt = dm2[ADDR_W-1:0];
            case (cmd_r.alu)
              ALU_ADD: begin
                res_nxt  = sum_val;
                stat_nxt = sum_sat ? ST_SAT : ST_OK;
              end
              ALU_SUB: begin
                res_nxt  = diff_val;
                stat_nxt = diff_sat ? ST_SAT : ST_OK;
              end
              ALU_MUL: begin
                state_nxt = S_MUL;
              end
              ALU_DIV: begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
              default: begin
                state_nxt = S_FIN;
              end
            endcase
          end
        end else if (cmd_r.peek) begin
          if (depth_r == '0) begin
            stat_nxt = ST_EMPTY;
          end else begin
            res_nxt = top_r;
          end
        end else begin
          stat_nxt = ST_INVALID;
        end
      end
      S_MUL: begin
        res_nxt   = mul_val;
        stat_nxt  = mul_fit ? ST_OK : ST_SAT;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        if (div_res.done) begin
          res_nxt   = div_res.value;
          stat_nxt  = div_res.sat ? ST_SAT : ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      skip_r      <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        depth_r     <= pdep_r;
        skip_r      <= pskip_r;
        err_r       <= perr_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
    pdep_r  <= pdep_nxt;
    perr_r  <= perr_nxt;
    pskip_r <= pskip_nxt;
    wen_r   <= wen_nxt;
    widx_r  <= widx_nxt;
    if (q_pop) begin
      cmd_r <= q_data;
    end
    if (state_r == S_EXEC) begin
      prod_r <= signed'(sub_r) * signed'(top_r);
    end
    if (fin) begin
      out_data_r.status       <= stat_r;
      out_data_r.result_value <= res_r;
      out_data_r.depth_out    <= DEPTH_OUT_W'(pdep_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      top_r <= stk_mem[dm1[ADDR_W-1:0]];
      sub_r <= stk_mem[dm2[ADDR_W-1:0]];
    end
    if (fin && wen_r) begin
      stk_mem[widx_r] <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/rpn_stack_calculator_top.sv
// RPN stack calculator top level: front end, command queue, execution unit and divider.
//
// Each input word is a decoded token and produces exactly one output word. A word waits in the
// input register, then passes through a two-entry queue to the execution unit, which handles
// one token at a time: pushes, add, subtract, peek, end of line and error cases go through its
// execute and finish states, multiply registers the product of one 32x32 multiplier and then
// rounds and clamps it, and divide waits on the radix-4 divider, which retires two quotient bits
// per cycle over the 48-bit scaled dividend. The input keeps accepting words while results wait
// in the output register, until the queue is full and the input register holds a word.
module rpn_stack_calculator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpn_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpn_pkg::out_word_t out_data
);
  import rpn_pkg::*;

  logic     push;
  cmd_t     push_data;
  logic     q_full;
  logic     q_pop;
  cmd_t     q_data;
  logic     q_empty;
  div_req_t div_req;
  div_res_t div_res;

  rpn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rpn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  rpn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  rpn_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_res   (div_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/tb_rpn_stack_calculator_top.sv
// Self-checking testbench of the RPN stack calculator: predicts every output word and compares.
module tb_rpn_stack_calculator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpn_pkg::*;

  localparam int     QUIET_LIMIT  = 4000;
  localparam int     HOLD_CYCLES  = 200;
  localparam int     SETTLE_WAIT  = 60;
  localparam int     REPORT_LIMIT = 200;
  localparam longint FRAC_SCALE   = 65536;
  localparam longint WIDE_MAX     = 64'sd2147483647;
  localparam longint WIDE_MIN     = -64'sd2147483648;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  logic signed [Q_W-1:0] stack_vals [STACK_DEPTH];
  int        calc_depth = 0;
  bit        skip_line = 1'b0;
  bit        line_err = 1'b0;

  out_word_t expected_words [$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_request = 1'b0;
  int        hold_left = 0;

  rpn_stack_calculator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic calc_token(input in_word_t w, output out_word_t r);
    longint lhs;
    longint rhs;
    longint wide;
    req_t   kind;
    kind = req_t'(w.req_type);
    r.status = ST_OK;
    r.result_value = '0;
    if (kind == REQ_EOL) begin
      if (line_err) begin
        r.status = ST_KEPT;
      end else begin
        r.status = ST_CLEARED;
        calc_depth = 0;
      end
      line_err = 1'b0;
      skip_line = 1'b0;
    end else if (skip_line) begin
      r.status = ST_SKIPPED;
    end else begin
      case (kind)
        REQ_NUM: begin
          if (calc_depth >= STACK_DEPTH) begin
            calc_depth = 0;
            line_err = 1'b1;
            skip_line = 1'b1;
            r.status = ST_OVERFLOW;
          end else begin
            stack_vals[calc_depth] = w.operand_value;
            calc_depth++;
            r.result_value = w.operand_value;
          end
        end
        REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
          if (calc_depth < 2) begin
            line_err = 1'b1;
            r.status = ST_UNDERFLOW;
          end else begin
            rhs = stack_vals[calc_depth-1];
            lhs = stack_vals[calc_depth-2];
            if (kind == REQ_DIV && rhs == 0) begin
              calc_depth--;
              r.result_value = lhs[Q_W-1:0];
              r.status = ST_DIVZERO;
            end else begin
              case (kind)
                REQ_ADD: wide = lhs + rhs;
                REQ_SUB: wide = lhs - rhs;
                REQ_MUL: wide = (lhs * rhs) / FRAC_SCALE;
                default: wide = (lhs * FRAC_SCALE) / rhs;
              endcase
              if (wide > WIDE_MAX) begin
                wide = WIDE_MAX;
                r.status = ST_SAT;
              end else if (wide < WIDE_MIN) begin
                wide = WIDE_MIN;
                r.status = ST_SAT;
              end
              calc_depth--;
              stack_vals[calc_depth-1] = wide[Q_W-1:0];
              r.result_value = wide[Q_W-1:0];
            end
          end
        end
        REQ_PEEK: begin
          if (calc_depth > 0) begin
            r.result_value = stack_vals[calc_depth-1];
          end else begin
            r.status = ST_EMPTY;
          end
        end
        default: r.status = ST_INVALID;
      endcase
    end
    r.depth_out = DEPTH_OUT_W'(calc_depth);
  endtask

  always @(posedge clk) begin : word_monitor
    out_word_t want;
    out_word_t pred;
    bit        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_words.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected word, got status %0d value %0d depth %0d", $time,
                     out_data.status, out_data.result_value, out_data.depth_out);
          end
        end else begin
          want = expected_words.pop_front();
          if (out_data.status !== want.status) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: status expected %0d, got %0d", $time,
                       want.status, out_data.status);
            end
          end
          if (out_data.result_value !== want.result_value) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: result_value expected %0d, got %0d", $time,
                       want.result_value, out_data.result_value);
            end
          end
          if (out_data.depth_out !== want.depth_out) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: depth_out expected %0d, got %0d", $time,
                       want.depth_out, out_data.depth_out);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        calc_token(in_data, pred);
        expected_words.push_back(pred);
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("rpn_stack_calculator_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_token(input req_t kind, input logic signed [Q_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: kind, operand_value: val};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [Q_W-1:0] rand_q();
    int pick;
    pick = $urandom_range(11);
    case (pick)
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return ($urandom_range(1) == 1) ? 32'sd1 : -32'sd1;
      4, 5, 6: return int'($urandom_range(20 * 65536)) - 10 * 65536;
      7, 8:    return (int'($urandom_range(16)) - 8) * 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_token(output req_t kind, output logic signed [Q_W-1:0] val);
    int roll;
    roll = $urandom_range(99);
    val = $urandom;
    if (roll < 15) begin
      kind = req_t'($urandom_range(7));
      if ($urandom_range(1) == 1) val = rand_q();
    end else if (skip_line) begin
      kind = ($urandom_range(3) == 0) ? req_t'($urandom_range(5)) : REQ_EOL;
    end else if (calc_depth < 2) begin
      roll = $urandom_range(9);
      if (roll < 8) kind = REQ_NUM;
      else if (roll == 8) kind = REQ_EOL;
      else kind = REQ_PEEK;
    end else if (calc_depth >= STACK_DEPTH) begin
      kind = ($urandom_range(9) == 0) ? REQ_NUM : req_t'($urandom_range(1, 4));
    end else begin
      roll = $urandom_range(99);
      if (roll < 40) kind = REQ_NUM;
      else if (roll < 85) kind = req_t'($urandom_range(1, 4));
      else if (roll < 92) kind = REQ_PEEK;
      else kind = REQ_EOL;
    end
    if (kind == REQ_NUM) val = rand_q();
  endtask

  task automatic run_token_stream(input int count);
    req_t                  kind;
    logic signed [Q_W-1:0] val;
    repeat (count) begin
      pick_token(kind, val);
      send_token(kind, val);
    end
    drain_results();
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_token(REQ_PEEK, '0);
    send_token(REQ_ADD, '0);
    send_token(REQ_EOL, '0);
    send_token(REQ_EOL, '1);
    send_token(REQ_NUM, Q_MAX);
    send_token(REQ_NUM, Q_MAX);
    send_token(REQ_ADD, '0);
    send_token(REQ_NUM, Q_MIN);
    send_token(REQ_SUB, '0);
    send_token(REQ_NUM, '0);
    send_token(REQ_DIV, '0);
    send_token(REQ_PEEK, '1);
    send_token(REQ_NUM, -32'sd1);
    send_token(REQ_MUL, '0);
    send_token(REQ_NUM, Q_MIN);
    send_token(REQ_DIV, '0);
    send_token(REQ_INVALID, '1);
    send_token(REQ_NUM, 32'sd65536);
    send_token(REQ_NUM, 32'sd131072);
    send_token(REQ_NUM, 32'sd196608);
    send_token(REQ_NUM, 32'sd1);
    send_token(REQ_MUL, '0);
    send_token(REQ_EOL, '0);
    send_token(REQ_NUM, Q_MIN);
    send_token(REQ_NUM, -32'sd1);
    send_token(REQ_DIV, '0);
    send_token(REQ_NUM, Q_MIN);
    send_token(REQ_MUL, '0);
    send_token(REQ_EOL, '0);
    drain_results();
  endtask

  task automatic test_streaming();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_token_stream(350);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 83;
    recv_stall_pct = 0;
    run_token_stream(300);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_token_stream(300);
  endtask

  task automatic test_mixed_idling();
    send_idle_pct = 22;
    recv_stall_pct = 22;
    run_token_stream(300);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    run_token_stream(40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure();
    recv_stall_pct = 0;
    repeat (SETTLE_WAIT) @(negedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("rpn_stack_calculator_top: match");
    end else begin
      $display("rpn_stack_calculator_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rpn_pkg.sv
rtl/rpn_front.sv
rtl/rpn_queue.sv
rtl/rpn_div.sv
rtl/rpn_exec.sv
rtl/rpn_stack_calculator_top.sv
tb/tb_rpn_stack_calculator_top.sv
